FILE: hdl/dvc_pkg.sv
package dvc_pkg;

    localparam int VALUE_BITS     = 32;   // width of the value field on the bus
    localparam int COUNT_BITS     = 7;    // width of repeat_count
    localparam int IN_TDATA_BITS  = 32;   // value, whole bytes
    localparam int OUT_TDATA_BITS = 8;    // repeat_count, overflow
    localparam int QUEUE_DEPTH    = 2;    // power of two
    localparam int QPTR_BITS      = 1;
    localparam int QCNT_BITS      = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                  last;
        logic [VALUE_BITS-1:0] value;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    // packed in tdata order: repeat_count in the low bits
    typedef struct packed {
        logic                  overflow;
        logic [COUNT_BITS-1:0] repeat_count;
    } t_result;

endpackage

FILE: hdl/dvc_queue.sv
module dvc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dvc_pkg::t_item      i_item,
    output logic                o_ready,
    output dvc_pkg::t_queue_head o_head,
    input  logic                i_pop
);

    dvc_pkg::t_item                  r_mem [dvc_pkg::QUEUE_DEPTH];
    logic [dvc_pkg::QPTR_BITS-1:0]   r_wr_ptr;
    logic [dvc_pkg::QPTR_BITS-1:0]   r_rd_ptr;
    logic [dvc_pkg::QCNT_BITS-1:0]   r_count;
    logic [dvc_pkg::QCNT_BITS-1:0]   n_count;
    logic                            push_ok;
    logic                            pop_ok;

    assign o_ready      = (r_count != dvc_pkg::QCNT_BITS'(dvc_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_head.valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: hdl/dvc_table.sv
module dvc_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dvc_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output dvc_pkg::t_result     o_result
);

    localparam int CMP_W  = (VALUE_WIDTH < dvc_pkg::VALUE_BITS) ? VALUE_WIDTH
                                                               : dvc_pkg::VALUE_BITS;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    logic [CMP_W-1:0]                r_seen [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]          r_valid;
    logic [TABLE_DEPTH-1:0]          r_counted;
    logic [USED_W-1:0]               r_used;
    logic [dvc_pkg::COUNT_BITS-1:0]  r_repeats;
    logic                            r_overflow;
    logic                            r_out_valid;
    dvc_pkg::t_result                r_out;

    logic [dvc_pkg::COUNT_BITS-1:0]  n_repeats;
    logic                            n_overflow;
    logic [CMP_W-1:0]                cmp_value;
    logic [TABLE_DEPTH-1:0]          match;
    logic                            hit;
    logic                            hit_counted;
    logic                            full;
    logic                            insert;
    logic                            out_free;
    logic                            take_last;

    assign cmp_value = i_head.item.value[CMP_W-1:0];

    // stored values are distinct, so at most one entry matches
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match[i] = r_valid[i] && (r_seen[i] == cmp_value);
        end
    end

    assign hit         = |match;
    assign hit_counted = |(match & r_counted);
    assign full        = (r_used == USED_W'(TABLE_DEPTH));
    assign insert      = !hit && !full;

    assign out_free  = !r_out_valid || i_m_tready;
    assign o_pop     = i_head.valid && (!i_head.item.last || out_free);
    assign take_last = o_pop && i_head.item.last;

    always_comb begin
        n_repeats = r_repeats;
        if (hit && !hit_counted && (r_repeats != dvc_pkg::COUNT_MAX)) begin
            n_repeats = r_repeats + 1'b1;
        end
        n_overflow = r_overflow || (!hit && full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_counted   <= '0;
            r_used      <= '0;
            r_repeats   <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_last) begin
                r_valid    <= '0;
                r_counted  <= '0;
                r_used     <= '0;
                r_repeats  <= '0;
                r_overflow <= 1'b0;
            end else if (o_pop) begin
                if (hit && !hit_counted) begin
                    r_counted <= r_counted | match;
                end
                if (insert) begin
                    r_valid[r_used[IDX_W-1:0]] <= 1'b1;
                    r_used                     <= r_used + 1'b1;
                end
                r_repeats  <= n_repeats;
                r_overflow <= n_overflow;
            end

            if (take_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && insert) begin
            r_seen[r_used[IDX_W-1:0]] <= cmp_value;
        end
        if (take_last) begin
            r_out.repeat_count <= n_repeats;
            r_out.overflow     <= n_overflow;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

endmodule

FILE: hdl/duplicate_value_counter.sv
// Channel   Dir  Handshake               Payload
// -------   ---  ----------------------  ------------------------------------------
// s (in)    in   i_s_tvalid/o_s_tready   tdata[31:0] = value, tlast = is_last
// m (out)   out  o_m_tvalid/i_m_tready   tdata[6:0] = repeat_count, tdata[7] = overflow
//
// One value per cycle unless the queue stalls: the whole table is compared and updated per value.
// Path of a last value: queue write, then table and result register, which offers the result.
// Synchronous active-low reset clears the valid and counted bits at once; no sweep.
// A last value waits at the queue head while the result register is still full;
// values behind it are still taken into the queue, and the input stalls once the two-entry queue fills.
module duplicate_value_counter #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dvc_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,   // [31:0] value
    input  logic                                i_s_tlast,   // is_last
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [dvc_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata    // [6:0] repeat_count, [7] overflow
);

    dvc_pkg::t_item       in_item;
    dvc_pkg::t_queue_head head;
    dvc_pkg::t_result     result;
    logic                 pop;

    assign in_item.value = i_s_tdata[dvc_pkg::VALUE_BITS-1:0];
    assign in_item.last  = i_s_tlast;

    // front: takes transactions and holds them until the table is free
    dvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_item  (in_item),
        .o_ready (o_s_tready),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back: lookup, mark, insert, and the result register
    dvc_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (result)
    );

    assign o_m_tdata = result;

endmodule

FILE: hdl/dvc_checker.sv
module dvc_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tready,
    input logic                               i_m_tvalid,
    input logic                               i_m_tready,
    input logic [dvc_pkg::OUT_TDATA_BITS-1:0] i_m_tdata
);

    localparam int COUNT_BOUND = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

    // reset empties both the queue and the result register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid && i_s_tready)
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // the queue only fills behind a result that is being held off
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid && $past(i_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // only table entries can be counted as repeats
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[dvc_pkg::COUNT_BITS-1:0]
                        <= dvc_pkg::COUNT_BITS'(COUNT_BOUND)))
        else $error("repeat count exceeds table depth");

endmodule

bind duplicate_value_counter dvc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_dvc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

FILE: bench/duplicate_value_counter_tb.sv
module duplicate_value_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH    = 64;     // table size the block is built with
    localparam int RANDOM_ITEMS = 1650;   // values queued in the random part
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction before the watchdog fires
    localparam int DRAIN_CYCLES = 8;      // idle margin once every result is back

    // Shapes of the random arrays
    typedef enum int {
        ARR_POOL,       // few distinct values, many repeats
        ARR_SPARSE,     // mostly fresh values, a few repeats
        ARR_FULL,       // exactly fills the table, then repeats stored values
        ARR_OVERFLOW,   // more distinct values than the table holds
        ARR_LONG        // longer mix of pooled and fresh values
    } t_array_kind;

    // ------------------------------------------------------------------
    // DUT connections, inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [dvc_pkg::IN_TDATA_BITS-1:0]  i_s_tdata  = '0;
    logic                               i_s_tlast  = 1'b0;
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [dvc_pkg::OUT_TDATA_BITS-1:0] o_m_tdata;

    duplicate_value_counter #(
        .TABLE_DEPTH (TBL_DEPTH),
        .VALUE_WIDTH (dvc_pkg::VALUE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    dvc_pkg::t_item   pending_items[$];     // values waiting for the driver
    dvc_pkg::t_result expected_results[$];  // predicted results, oldest first
    logic [31:0]      build_vals[$];        // array under construction

    int items_pushed   = 0;
    int items_accepted = 0;
    int arrays_queued  = 0;
    int results_seen   = 0;
    int ovf_results    = 0;
    int max_count      = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the distinct-value table
    // ------------------------------------------------------------------
    logic [dvc_pkg::VALUE_BITS-1:0] tbl_value [TBL_DEPTH];
    bit   [TBL_DEPTH-1:0]           tbl_valid   = '0;
    bit   [TBL_DEPTH-1:0]           tbl_counted = '0;
    int                             tbl_used    = 0;
    logic [dvc_pkg::COUNT_BITS-1:0] rep_count   = '0;
    bit                             ovf_flag    = 1'b0;

    // Takes one value into the table; returns 1 with the result on the last value.
    function automatic bit track_value(input logic [dvc_pkg::VALUE_BITS-1:0] value,
                                       input logic last,
                                       output dvc_pkg::t_result res);
        bit hit;
        hit = 1'b0;
        res = '0;
        // Match is on the raw bit pattern; only the first matching slot matters.
        for (int k = 0; k < TBL_DEPTH; k++) begin
            if (!hit && tbl_valid[k] && tbl_value[k] == value) begin
                hit = 1'b1;
                if (!tbl_counted[k]) begin
                    tbl_counted[k] = 1'b1;
                    // saturates at the largest 7-bit count
                    if (rep_count != dvc_pkg::COUNT_MAX)
                        rep_count++;
                end
            end
        end
        if (!hit) begin
            if (tbl_used < TBL_DEPTH) begin
                tbl_value[tbl_used]   = value;
                tbl_valid[tbl_used]   = 1'b1;
                tbl_counted[tbl_used] = 1'b0;
                tbl_used++;
            end else begin
                ovf_flag = 1'b1;   // table full: value dropped
            end
        end
        if (!last)
            return 1'b0;
        res.repeat_count = rep_count;
        res.overflow     = ovf_flag;
        // end of array: start over for the next one
        tbl_valid   = '0;
        tbl_counted = '0;
        tbl_used    = 0;
        rep_count   = '0;
        ovf_flag    = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got_v, want_v);
        mismatches++;
    endtask

    // Mostly short idles, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;    // stretch with no idling
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: updates at the falling edge
    // ------------------------------------------------------------------
    int s_gap_left  = 0;
    int s_gap_pct   = 0;
    int s_mode_left = 0;
    int s_acc_seen  = 0;   // accept count at the previous falling edge

    always @(negedge i_clk) begin
        bit             taken;
        dvc_pkg::t_item it;
        // the held input transaction went through at the last rising edge
        taken      = (items_accepted != s_acc_seen);
        s_acc_seen = items_accepted;
        if (s_mode_left == 0) begin
            s_gap_pct   = pick_idle_pct();
            s_mode_left = $urandom_range(100, 600);
        end else begin
            s_mode_left--;
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !taken) begin
            // hold the offered transaction until it is accepted
        end else if (s_gap_left > 0) begin
            s_gap_left--;
            i_s_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
            i_s_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < s_gap_pct) begin
            s_gap_left = pick_gap() - 1;
            i_s_tvalid <= 1'b0;
        end else begin
            it = pending_items.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= it.value;
            i_s_tlast  <= it.last;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random backpressure, also at the falling edge
    // ------------------------------------------------------------------
    int m_stall_left = 0;
    int m_stall_pct  = 0;
    int m_mode_left  = 0;

    always @(negedge i_clk) begin
        if (m_mode_left == 0) begin
            m_stall_pct = pick_idle_pct();
            m_mode_left = $urandom_range(100, 600);
        end else begin
            m_mode_left--;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (m_stall_left > 0) begin
            m_stall_left--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < m_stall_pct) begin
            m_stall_left = pick_gap() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both sides at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dvc_pkg::t_result got;
        dvc_pkg::t_result want;
        dvc_pkg::t_result pred;
        bit               busy;
        busy = 1'b0;
        if (i_rst_n) begin
            // input side first: a last value taken now can't produce its result this edge
            if (i_s_tvalid && o_s_tready) begin
                busy = 1'b1;
                items_accepted++;
                if (track_value(i_s_tdata[dvc_pkg::VALUE_BITS-1:0], i_s_tlast, pred))
                    expected_results.push_back(pred);
            end
            if (o_m_tvalid && i_m_tready) begin
                busy = 1'b1;
                got  = dvc_pkg::t_result'(o_m_tdata);
                results_seen++;
                if (got.overflow)
                    ovf_results++;
                if (int'(got.repeat_count) > max_count)
                    max_count = int'(got.repeat_count);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction, repeat_count",
                                    int'(got.repeat_count), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.repeat_count != want.repeat_count)
                        report_mismatch("repeat_count", int'(got.repeat_count),
                                        int'(want.repeat_count));
                    if (got.overflow != want.overflow)
                        report_mismatch("overflow", int'(got.overflow),
                                        int'(want.overflow));
                end
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    // Watchdog: a long stretch with no transaction at all means a hang
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Moves build_vals into the driver queue, tlast on the final value
    task automatic flush_array();
        dvc_pkg::t_item it;
        for (int i = 0; i < build_vals.size(); i++) begin
            it.value = build_vals[i];
            it.last  = (i == build_vals.size() - 1);
            pending_items.push_back(it);
        end
        items_pushed += build_vals.size();
        arrays_queued++;
    endtask

    // Sender stops until every queued value went in and every result came out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_pushed || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_random_arrays(input int n_items, input bit force_wide);
        int          stop_at;
        int          lead;
        int          len;
        int          pool_n;
        int          span;
        int          roll;
        t_array_kind kind;
        logic [31:0] base;
        logic [31:0] stride;
        logic [31:0] pool [8];
        stop_at = items_pushed + n_items;
        // lead-in: a full table repeated entirely, then an overflowing array
        lead = force_wide ? 2 : 0;
        while (items_pushed < stop_at) begin
            if (lead == 2) begin
                kind = ARR_FULL;
            end else if (lead == 1) begin
                kind = ARR_OVERFLOW;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55)      kind = ARR_POOL;
                else if (roll < 80) kind = ARR_SPARSE;
                else if (roll < 86) kind = ARR_FULL;
                else if (roll < 92) kind = ARR_OVERFLOW;
                else                kind = ARR_LONG;
            end
            pool_n = $urandom_range(1, 8);
            for (int i = 0; i < 8; i++)
                pool[i] = ($urandom_range(0, 15) == 0) ? corner_value() : $urandom;
            // odd stride keeps base + i*stride distinct for every i in range
            base   = $urandom;
            stride = $urandom | 32'd1;
            build_vals.delete();
            case (kind)
                ARR_POOL: begin
                    len = $urandom_range(1, 24);
                    repeat (len) build_vals.push_back(pool[$urandom_range(0, pool_n - 1)]);
                end
                ARR_SPARSE: begin
                    len = $urandom_range(1, 16);
                    repeat (len) begin
                        if (build_vals.size() > 0 && $urandom_range(0, 3) == 0)
                            build_vals.push_back(
                                build_vals[$urandom_range(0, build_vals.size() - 1)]);
                        else
                            build_vals.push_back($urandom);
                    end
                end
                ARR_FULL: begin
                    for (int i = 0; i < TBL_DEPTH; i++)
                        build_vals.push_back(base + 32'(i) * stride);
                    if (lead == 2 || $urandom_range(0, 2) == 0) begin
                        // every entry repeated: largest count the table allows
                        for (int i = 0; i < TBL_DEPTH; i++)
                            build_vals.push_back(base + 32'(i) * stride);
                    end else begin
                        repeat ($urandom_range(1, 40))
                            build_vals.push_back(
                                base + 32'($urandom_range(0, TBL_DEPTH - 1)) * stride);
                    end
                end
                ARR_OVERFLOW: begin
                    span = TBL_DEPTH + $urandom_range(1, 16);
                    for (int i = 0; i < span; i++)
                        build_vals.push_back(base + 32'(i) * stride);
                    // repeats of stored and of dropped values alike
                    repeat ($urandom_range(1, 30))
                        build_vals.push_back(base + 32'($urandom_range(0, span - 1)) * stride);
                end
                default: begin
                    len = $urandom_range(25, 60);
                    repeat (len) begin
                        if ($urandom_range(0, 1) == 0)
                            build_vals.push_back(pool[$urandom_range(0, pool_n - 1)]);
                        else
                            build_vals.push_back($urandom);
                    end
                end
            endcase
            if (lead > 0)
                lead--;
            flush_array();
        end
    endtask

    initial begin
        // Directed arrays
        // single value that is also the last: count 0
        build_vals = '{32'h0000_0000};
        flush_array();
        // field extremes; a third hit on one value is not counted again
        build_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        flush_array();
        // the repeat sits on the last value itself
        build_vals = '{32'h0000_0005, 32'h0000_0005};
        flush_array();
        // same low bits, different sign bit: distinct values
        build_vals = '{32'h0000_0001, 32'h8000_0001, 32'h8000_0001, 32'h0000_0001};
        flush_array();
        // table is cleared between arrays: the second one starts at zero
        build_vals = '{32'h1234_5678};
        flush_array();
        build_vals = '{32'h1234_5678};
        flush_array();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        queue_random_arrays(RANDOM_ITEMS / 2, 1'b1);
        wait_drained();   // sender holds off until every result is back
        queue_random_arrays(RANDOM_ITEMS / 2, 1'b0);
        wait_drained();

        $display("Ran %0d arrays, %0d values in, %0d results checked",
                 arrays_queued, items_accepted, results_seen);
        $display("%0d results with table overflow, largest repeat count seen %0d",
                 ovf_results, max_count);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dvc_pkg.sv
hdl/dvc_queue.sv
hdl/dvc_table.sv
hdl/duplicate_value_counter.sv
hdl/dvc_checker.sv
bench/duplicate_value_counter_tb.sv
